@@ hw/rtl/iee_pkg.sv @@
// ----------------------------------------------------------------------------
// iee_pkg: shared types and constants of the infix expression evaluator
// Beat structs, token classes, operator codes, status codes, ALU interface.
// ----------------------------------------------------------------------------
package iee_pkg;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} item_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic [1:0]         status;
	} result_t;

	typedef enum logic [2:0] {
		CLS_DIGIT,
		CLS_STAR,
		CLS_PLUS,
		CLS_MINUS,
		CLS_SLASH,
		CLS_OTHER
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [3:0] digit;
		logic       last;
	} token_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV,
		ALU_PSTEP
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic sat;
		logic div_zero;
	} alu_rsp_t;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;
	localparam logic [1:0] ST_BAD = 2'd3;

	localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
	localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam int QUEUE_DEPTH = 2;

	function automatic logic [63:0] magnitude(input logic [63:0] x);
		return x[63] ? (64'd0 - x) : x;
	endfunction

endpackage

@@ hw/rtl/iee_front.sv @@
// ----------------------------------------------------------------------------
// iee_front: character classifier and token queue
// Decodes each input beat into a token and holds it in a short queue.
// ----------------------------------------------------------------------------
module iee_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  iee_pkg::item_t  item,
	output logic            tok_valid,
	output iee_pkg::token_t tok,
	input  logic            tok_pop
);
	import iee_pkg::*;

	localparam int PtrBits = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	token_t             ent_q [QUEUE_DEPTH];
	logic [PtrBits-1:0] wr_q, rd_q;
	logic [PtrBits:0]   cnt_q;
	token_t             dec;
	logic               wr_en, rd_en;

	always_comb begin
		dec.last  = item.last;
		dec.digit = item.character[3:0];
		if (item.character >= CH_ZERO && item.character <= CH_NINE) begin
			dec.cls = CLS_DIGIT;
		end else begin
			unique case (item.character)
				CH_STAR:  dec.cls = CLS_STAR;
				CH_PLUS:  dec.cls = CLS_PLUS;
				CH_MINUS: dec.cls = CLS_MINUS;
				CH_SLASH: dec.cls = CLS_SLASH;
				default:  dec.cls = CLS_OTHER;
			endcase
		end
	end

	assign full      = (cnt_q == (PtrBits+1)'(QUEUE_DEPTH));
	assign tok_valid = (cnt_q != '0);
	assign tok       = ent_q[rd_q];
	assign wr_en     = push && !full;
	assign rd_en     = tok_pop && tok_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en)
				wr_q <= wr_q + 1'b1;
			if (rd_en)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrBits+1)'(wr_en) - (PtrBits+1)'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			ent_q[wr_q] <= dec;
	end

endmodule

@@ hw/rtl/iee_alu.sv @@
// ----------------------------------------------------------------------------
// iee_alu: saturating fixed-point arithmetic unit
// Add/sub in one pass, multiply from four 32x32 partials, restoring divide.
// ----------------------------------------------------------------------------
module iee_alu #(
	parameter int FRACTION_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  iee_pkg::alu_req_t req,
	input  logic [63:0]       a,
	input  logic [63:0]       b,
	output iee_pkg::alu_rsp_t rsp,
	output logic [63:0]       res,
	output logic              busy
);
	import iee_pkg::*;

	localparam int DivSteps = 64 + FRACTION_BITS;
	localparam int CntBits  = $clog2(DivSteps + 1);
	localparam logic [127:0] Half = 128'(1) << (FRACTION_BITS - 1);

	typedef enum logic [2:0] {
		A_IDLE,
		A_MUL,
		A_RND,
		A_DIV,
		A_DRND,
		A_PACK
	} state_t;

	state_t             state_q;
	logic [63:0]        am_q, bm_q, rem_q, pp_s1, res_q;
	logic [127:0]       prod_q, num_q;
	logic [1:0]         sh_s1;
	logic [2:0]         k_q;
	logic [CntBits-1:0] cnt_q;
	logic               neg_q, pstep_q;
	alu_rsp_t           rsp_q;

	logic [31:0]  ah, bh;
	logic [63:0]  pp_c, sum_c, dif_c, rem2, lim;
	logic [127:0] pp_sh;

	assign ah    = k_q[1] ? am_q[63:32] : am_q[31:0];
	assign bh    = k_q[0] ? bm_q[63:32] : bm_q[31:0];
	assign pp_c  = ah * bh;
	assign sum_c = a + b;
	assign dif_c = a - b;
	assign rem2  = {rem_q[62:0], num_q[63+FRACTION_BITS]};
	assign lim   = (neg_q || pstep_q) ? SIGN_BIT : POS_MAX;

	always_comb begin
		case (sh_s1)
			2'd0:    pp_sh = {64'd0, pp_s1};
			2'd1:    pp_sh = {32'd0, pp_s1, 32'd0};
			default: pp_sh = {pp_s1, 64'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			rsp_q   <= '0;
			res_q   <= '0;
			am_q    <= '0;
			bm_q    <= '0;
			rem_q   <= '0;
			pp_s1   <= '0;
			prod_q  <= '0;
			num_q   <= '0;
			sh_s1   <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			pstep_q <= 1'b0;
		end else begin
			rsp_q <= '0;
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						neg_q   <= (req.op != ALU_PSTEP) && (a[63] ^ b[63]);
						pstep_q <= (req.op == ALU_PSTEP);
						prod_q  <= '0;
						k_q     <= '0;
						cnt_q   <= '0;
						rem_q   <= '0;
						case (req.op)
							ALU_ADD: begin
								rsp_q.done <= 1'b1;
								if (a[63] == b[63] && sum_c[63] != a[63]) begin
									rsp_q.sat <= 1'b1;
									res_q     <= a[63] ? SIGN_BIT : POS_MAX;
								end else begin
									res_q <= sum_c;
								end
							end
							ALU_SUB: begin
								rsp_q.done <= 1'b1;
								if (a[63] != b[63] && dif_c[63] != a[63]) begin
									rsp_q.sat <= 1'b1;
									res_q     <= a[63] ? SIGN_BIT : POS_MAX;
								end else begin
									res_q <= dif_c;
								end
							end
							ALU_DIV: begin
								if (b == '0) begin
									rsp_q.done     <= 1'b1;
									rsp_q.div_zero <= 1'b1;
									res_q          <= '0;
								end else begin
									num_q   <= 128'(magnitude(a)) << FRACTION_BITS;
									bm_q    <= magnitude(b);
									state_q <= A_DIV;
								end
							end
							default: begin
								am_q    <= (req.op == ALU_PSTEP) ? a : magnitude(a);
								bm_q    <= (req.op == ALU_PSTEP) ? b : magnitude(b);
								state_q <= A_MUL;
							end
						endcase
					end
				end
				A_MUL: begin
					// partial k is formed while partial k-1 is accumulated
					if (k_q != 3'd4) begin
						pp_s1 <= pp_c;
						sh_s1 <= {1'b0, k_q[1]} + {1'b0, k_q[0]};
					end
					if (k_q != 3'd0)
						prod_q <= prod_q + pp_sh;
					if (k_q == 3'd4)
						state_q <= A_RND;
					else
						k_q <= k_q + 3'd1;
				end
				A_RND: begin
					prod_q  <= (prod_q + Half) >> FRACTION_BITS;
					state_q <= A_PACK;
				end
				A_DIV: begin
					if (rem2 >= bm_q) begin
						rem_q  <= rem2 - bm_q;
						prod_q <= {prod_q[126:0], 1'b1};
					end else begin
						rem_q  <= rem2;
						prod_q <= {prod_q[126:0], 1'b0};
					end
					num_q <= num_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntBits'(DivSteps - 1))
						state_q <= A_DRND;
				end
				A_DRND: begin
					if (rem_q >= bm_q - rem_q)
						prod_q <= prod_q + 128'd1;
					state_q <= A_PACK;
				end
				A_PACK: begin
					rsp_q.done <= 1'b1;
					if (prod_q[127:64] != '0 || prod_q[63:0] > lim) begin
						rsp_q.sat <= 1'b1;
						res_q     <= lim;
					end else begin
						res_q <= neg_q ? (64'd0 - prod_q[63:0]) : prod_q[63:0];
					end
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign rsp  = rsp_q;
	assign res  = res_q;
	assign busy = (state_q != A_IDLE);

endmodule

@@ hw/rtl/iee_back.sv @@
// ----------------------------------------------------------------------------
// iee_back: expression sequencer
// Runs tokens against the value and operator stacks and drives the result.
// ----------------------------------------------------------------------------
module iee_back #(
	parameter int FRACTION_BITS = 32,
	parameter int LITERAL_BITS  = 31
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_valid,
	input  iee_pkg::token_t   tok,
	output logic              tok_pop,
	output iee_pkg::alu_req_t alu_req,
	output logic [63:0]       alu_a,
	output logic [63:0]       alu_b,
	input  iee_pkg::alu_rsp_t alu_rsp,
	input  logic [63:0]       alu_res,
	input  logic              alu_busy,
	output logic              empty,
	input  logic              pop,
	output iee_pkg::result_t  result
);
	import iee_pkg::*;

	localparam int BitW = $clog2(LITERAL_BITS);
	localparam int AccW = LITERAL_BITS + 4;
	localparam logic [63:0] QOne = 64'(1) << FRACTION_BITS;
	localparam logic [AccW-1:0] LitMax = AccW'({LITERAL_BITS{1'b1}});

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_FIN,
		S_PW_SQ,
		S_PW_SQW,
		S_PW_MW,
		S_PW_NEXT,
		S_PW_END,
		S_COMMIT,
		S_RED_CHK,
		S_RED_W,
		S_PUSHOP,
		S_DIGIT,
		S_END,
		S_EMIT
	} state_t;

	state_t                  state_q, fin_next_q, red_next_q;
	token_t                  tok_q;
	logic [63:0]             vs0_q, vs1_q, vs2_q;
	op_t                     os0_q, os1_q, cm_q;
	logic [1:0]              opc_q, vc_q, err_q;
	logic [LITERAL_BITS-1:0] acc_q, exp_q;
	logic                    star_q, pp_q, digit_q, red_all_q;
	logic [63:0]             m_q, bmag_q;
	logic                    pneg_q, psat_q;
	logic [BitW-1:0]         bit_q;
	alu_req_t                alu_req_q;
	logic [63:0]             alu_a_q, alu_b_q;
	result_t                 res_q;
	logic                    rvalid_q;

	logic            halted, emit_go;
	logic [AccW-1:0] acc_next;
	logic [63:0]     bottom, plim;

	function automatic logic [1:0] raise(input logic [1:0] cur, input logic [1:0] code);
		if (code == ST_SAT)
			return (cur == ST_OK) ? ST_SAT : cur;
		return (cur == ST_OK || cur == ST_SAT) ? code : cur;
	endfunction

	assign halted   = (err_q == ST_DIV) || (err_q == ST_BAD);
	assign emit_go  = (state_q == S_EMIT) && (!rvalid_q || pop);
	assign tok_pop  = (state_q == S_IDLE) && tok_valid;
	assign acc_next = (AccW'(acc_q) << 3) + (AccW'(acc_q) << 1) + AccW'(tok_q.digit);
	assign plim     = pneg_q ? SIGN_BIT : POS_MAX;

	always_comb begin
		case (vc_q)
			2'd1:    bottom = vs0_q;
			2'd2:    bottom = vs1_q;
			2'd3:    bottom = vs2_q;
			default: bottom = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fin_next_q <= S_END;
			red_next_q <= S_PUSHOP;
			tok_q      <= '0;
			vs0_q      <= '0;
			vs1_q      <= '0;
			vs2_q      <= '0;
			os0_q      <= OP_ADD;
			os1_q      <= OP_ADD;
			cm_q       <= OP_ADD;
			opc_q      <= '0;
			vc_q       <= '0;
			err_q      <= ST_OK;
			acc_q      <= '0;
			exp_q      <= '0;
			star_q     <= 1'b0;
			pp_q       <= 1'b0;
			digit_q    <= 1'b0;
			red_all_q  <= 1'b0;
			m_q        <= '0;
			bmag_q     <= '0;
			pneg_q     <= 1'b0;
			psat_q     <= 1'b0;
			bit_q      <= '0;
			alu_req_q  <= '0;
			alu_a_q    <= '0;
			alu_b_q    <= '0;
			res_q      <= '0;
			rvalid_q   <= 1'b0;
		end else begin
			alu_req_q.start <= 1'b0;
			if (pop && rvalid_q)
				rvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (tok_valid) begin
						tok_q   <= tok;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (halted) begin
						state_q <= S_END;
					end else begin
						unique case (tok_q.cls)
							CLS_DIGIT: begin
								if (star_q) begin
									star_q  <= 1'b0;
									cm_q    <= OP_MUL;
									state_q <= S_COMMIT;
								end else begin
									state_q <= S_DIGIT;
								end
							end
							CLS_STAR: begin
								if (star_q) begin
									star_q  <= 1'b0;
									pp_q    <= 1'b1;
									state_q <= S_END;
								end else if (!digit_q) begin
									err_q   <= raise(err_q, ST_BAD);
									state_q <= S_END;
								end else begin
									star_q     <= 1'b1;
									fin_next_q <= S_END;
									state_q    <= S_FIN;
								end
							end
							CLS_PLUS, CLS_MINUS, CLS_SLASH: begin
								if (star_q || !digit_q) begin
									err_q   <= raise(err_q, ST_BAD);
									state_q <= S_END;
								end else begin
									case (tok_q.cls)
										CLS_PLUS:  cm_q <= OP_ADD;
										CLS_MINUS: cm_q <= OP_SUB;
										default:   cm_q <= OP_DIV;
									endcase
									fin_next_q <= S_COMMIT;
									state_q    <= S_FIN;
								end
							end
							default: begin
								err_q   <= raise(err_q, ST_BAD);
								state_q <= S_END;
							end
						endcase
					end
				end
				S_FIN: begin
					acc_q   <= '0;
					digit_q <= 1'b0;
					if (pp_q) begin
						pp_q <= 1'b0;
						if (vc_q != 2'd0) begin
							m_q     <= QOne;
							bmag_q  <= magnitude(vs0_q);
							pneg_q  <= vs0_q[63] && acc_q[0];
							psat_q  <= 1'b0;
							exp_q   <= acc_q;
							bit_q   <= BitW'(LITERAL_BITS - 1);
							state_q <= S_PW_SQ;
						end else begin
							state_q <= fin_next_q;
						end
					end else begin
						if (vc_q != 2'd3) begin
							vs2_q <= vs1_q;
							vs1_q <= vs0_q;
							vs0_q <= 64'(acc_q) << FRACTION_BITS;
							vc_q  <= vc_q + 2'd1;
						end
						state_q <= fin_next_q;
					end
				end
				// square and multiply, exponent bits from the top down
				S_PW_SQ: begin
					alu_req_q <= '{start: 1'b1, op: ALU_PSTEP};
					alu_a_q   <= m_q;
					alu_b_q   <= m_q;
					state_q   <= S_PW_SQW;
				end
				S_PW_SQW: begin
					if (alu_rsp.done) begin
						m_q    <= alu_res;
						psat_q <= psat_q | alu_rsp.sat;
						if (exp_q[bit_q]) begin
							alu_req_q <= '{start: 1'b1, op: ALU_PSTEP};
							alu_a_q   <= alu_res;
							alu_b_q   <= bmag_q;
							state_q   <= S_PW_MW;
						end else begin
							state_q <= S_PW_NEXT;
						end
					end
				end
				S_PW_MW: begin
					if (alu_rsp.done) begin
						m_q     <= alu_res;
						psat_q  <= psat_q | alu_rsp.sat;
						state_q <= S_PW_NEXT;
					end
				end
				S_PW_NEXT: begin
					if (bit_q == '0) begin
						state_q <= S_PW_END;
					end else begin
						bit_q   <= bit_q - 1'b1;
						state_q <= S_PW_SQ;
					end
				end
				S_PW_END: begin
					if (psat_q || m_q > plim) begin
						err_q <= raise(err_q, ST_SAT);
						vs0_q <= plim;
					end else begin
						vs0_q <= pneg_q ? (64'd0 - m_q) : m_q;
					end
					state_q <= fin_next_q;
				end
				S_COMMIT: begin
					red_next_q <= S_PUSHOP;
					if (cm_q == OP_ADD || cm_q == OP_SUB) begin
						red_all_q <= 1'b1;
						state_q   <= S_RED_CHK;
					end else if (opc_q != 2'd0 && os0_q[1]) begin
						red_all_q <= 1'b0;
						state_q   <= S_RED_CHK;
					end else begin
						state_q <= S_PUSHOP;
					end
				end
				S_RED_CHK: begin
					if (opc_q != 2'd0 && vc_q >= 2'd2 && (!red_all_q || !halted)) begin
						alu_req_q.start <= 1'b1;
						case (os0_q)
							OP_ADD:  alu_req_q.op <= ALU_ADD;
							OP_SUB:  alu_req_q.op <= ALU_SUB;
							OP_MUL:  alu_req_q.op <= ALU_MUL;
							default: alu_req_q.op <= ALU_DIV;
						endcase
						alu_a_q <= vs1_q;
						alu_b_q <= vs0_q;
						state_q <= S_RED_W;
					end else begin
						state_q <= red_next_q;
					end
				end
				S_RED_W: begin
					if (alu_rsp.done) begin
						vs0_q <= alu_res;
						vs1_q <= vs2_q;
						vc_q  <= vc_q - 2'd1;
						os0_q <= os1_q;
						opc_q <= opc_q - 2'd1;
						if (alu_rsp.div_zero)
							err_q <= raise(err_q, ST_DIV);
						else if (alu_rsp.sat)
							err_q <= raise(err_q, ST_SAT);
						state_q <= red_all_q ? S_RED_CHK : red_next_q;
					end
				end
				S_PUSHOP: begin
					if (!halted && opc_q != 2'd2) begin
						os1_q <= os0_q;
						os0_q <= cm_q;
						opc_q <= opc_q + 2'd1;
					end
					state_q <= (tok_q.cls == CLS_DIGIT) ? S_DIGIT : S_END;
				end
				S_DIGIT: begin
					if (!halted) begin
						if (acc_next > LitMax) begin
							acc_q <= LITERAL_BITS'(LitMax);
							err_q <= raise(err_q, ST_SAT);
						end else begin
							acc_q <= LITERAL_BITS'(acc_next);
						end
						digit_q <= 1'b1;
					end
					state_q <= S_END;
				end
				S_END: begin
					if (!tok_q.last) begin
						state_q <= S_IDLE;
					end else if (halted) begin
						state_q <= S_EMIT;
					end else if (star_q || !digit_q) begin
						err_q   <= raise(err_q, ST_BAD);
						state_q <= S_EMIT;
					end else begin
						fin_next_q <= S_RED_CHK;
						red_all_q  <= 1'b1;
						red_next_q <= S_EMIT;
						state_q    <= S_FIN;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						res_q.value  <= (halted || vc_q == 2'd0) ? 64'd0 : bottom;
						res_q.status <= err_q;
						rvalid_q     <= 1'b1;
						vc_q         <= '0;
						opc_q        <= '0;
						acc_q        <= '0;
						star_q       <= 1'b0;
						pp_q         <= 1'b0;
						digit_q      <= 1'b0;
						err_q        <= ST_OK;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign alu_req = alu_req_q;
	assign alu_a   = alu_a_q;
	assign alu_b   = alu_b_q;
	assign empty   = !rvalid_q;
	assign result  = res_q;

`ifndef NO_ASSERTIONS
	a_reduce_operands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RED_W && alu_rsp.done) |-> (vc_q >= 2'd2 && opc_q != 2'd0))
		else $error("reduction finished without two values and an operator");

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(halted && !emit_go) |=> halted)
		else $error("divide-by-zero or malformed status dropped before emit");

	a_halt_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rvalid_q && (res_q.status == ST_DIV || res_q.status == ST_BAD))
		|-> (res_q.value == 64'd0))
		else $error("error result carries a nonzero value");

	a_alu_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		alu_req_q.start |-> !alu_busy)
		else $error("arithmetic unit started while busy");
`endif

endmodule

@@ hw/rtl/infix_expression_evaluator_unit.sv @@
// ----------------------------------------------------------------------------
// infix_expression_evaluator_unit: streaming infix expression evaluator
// Evaluates + - * / ** over decimal literals in saturating signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: one ASCII character per beat on item (push/full); item.last
//   marks the final character of an expression.
//   Result queue: one beat per expression on result (empty/pop), carrying the
//   Q(64-F).F value and a status (ok, divide by zero, saturated, malformed).
//   A two-entry token queue parts the classifier from the sequencer, so
//   characters keep landing while an operator is being reduced.
//   Cost: a digit passes the sequencer's idle, decode, digit and end states;
//   an operator adds one request to the shared unit per reduction; a
//   multiply forms four partials there, a divide restores bit by bit, and
//   a power takes up to 2*LITERAL_BITS multiplies. The shared unit sets the rate.
//   Reset clears the stacks, the token queue and the result register; no
//   clearing pass is needed. A result not yet popped holds in the output
//   register; the sequencer then waits at the end of the next expression.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_unit #(
	parameter int FRACTION_BITS = 32,
	parameter int LITERAL_BITS  = 31
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  iee_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output iee_pkg::result_t result
);
	import iee_pkg::*;

	logic        tok_valid, tok_pop, alu_busy;
	token_t      tok;
	alu_req_t    alu_req;
	alu_rsp_t    alu_rsp;
	logic [63:0] alu_a, alu_b, alu_res;

	iee_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_pop   (tok_pop)
	);

	iee_alu #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (alu_a),
		.b      (alu_b),
		.rsp    (alu_rsp),
		.res    (alu_res),
		.busy   (alu_busy)
	);

	iee_back #(
		.FRACTION_BITS (FRACTION_BITS),
		.LITERAL_BITS  (LITERAL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_pop   (tok_pop),
		.alu_req   (alu_req),
		.alu_a     (alu_a),
		.alu_b     (alu_b),
		.alu_rsp   (alu_rsp),
		.alu_res   (alu_res),
		.alu_busy  (alu_busy),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the infix expression evaluator
// Streams expressions one character per beat, predicts each result in Q32.32
// with a local evaluator and compares value and status as results pop.
// ----------------------------------------------------------------------------
module tb_top;
	import iee_pkg::*;

	localparam int FRAC = 32;
	localparam int LBITS = 31;
	localparam logic [63:0] LIT_MAX = (64'd1 << LBITS) - 1;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	item_t item = '0;
	logic full, empty;
	result_t result;

	infix_expression_evaluator_unit i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result)
	);

	always #5 clk = ~clk;

	// evaluator state
	logic [63:0] vstk [3];
	op_t ostk [2];
	int unsigned n_ops, n_vals;
	logic [63:0] lit_acc;
	bit star_wait, pow_wait, in_lit;
	logic [1:0] err;

	result_t expected_results [$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit timed_out = 0;
	bit push_hold = 0;

	task automatic clear_eval();
		vstk = '{default: '0};
		ostk = '{default: OP_ADD};
		n_ops = 0; n_vals = 0; lit_acc = 0;
		star_wait = 0; pow_wait = 0; in_lit = 0; err = ST_OK;
	endtask

	function automatic void flag(logic [1:0] code);
		if (code == ST_SAT) begin
			if (err == ST_OK) err = ST_SAT;
		end else if (err == ST_OK || err == ST_SAT) begin
			err = code;
		end
	endfunction

	function automatic bit stopped();
		return err == ST_DIV || err == ST_BAD;
	endfunction

	function automatic logic [63:0] mag(logic [63:0] x);
		return x[63] ? -x : x;
	endfunction

	// rounded magnitude product, shifted by FRAC; returns 128 bits
	function automatic logic [127:0] mul_round(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p + (128'd1 << (FRAC - 1));
		return p >> FRAC;
	endfunction

	function automatic logic [63:0] fit(bit neg, logic [127:0] m);
		logic [63:0] lim;
		lim = neg ? SIGN_BIT : POS_MAX;
		if (m[127:64] != 0 || m[63:0] > lim) begin
			flag(ST_SAT);
			return lim;
		end
		return neg ? -m[63:0] : m[63:0];
	endfunction

	function automatic logic [63:0] fx_add(logic [63:0] a, logic [63:0] b, bit sub);
		logic [63:0] r;
		logic [63:0] bb;
		bb = sub ? ~b : b;
		r = sub ? a - b : a + b;
		if (a[63] == bb[63] && a[63] != r[63]) begin
			flag(ST_SAT);
			r = a[63] ? SIGN_BIT : POS_MAX;
		end
		return r;
	endfunction

	function automatic logic [63:0] fx_div(logic [63:0] a, logic [63:0] b);
		logic [127:0] n, q, rm;
		if (b == 0) begin
			flag(ST_DIV);
			return 0;
		end
		n = {64'd0, mag(a)} << FRAC;
		q = n / {64'd0, mag(b)};
		rm = n % {64'd0, mag(b)};
		if (rm >= {64'd0, mag(b)} - rm) q = q + 1;
		return fit(a[63] ^ b[63], q);
	endfunction

	function automatic logic [63:0] fx_pow(logic [63:0] base, logic [63:0] e);
		logic [63:0] bm, m;
		logic [127:0] p;
		bit ovf, neg;
		bm = mag(base);
		m = 64'd1 << FRAC;
		ovf = 0;
		neg = base[63] && e[0];
		for (int i = LBITS - 1; i >= 0; i--) begin
			p = mul_round(m, m);
			if (p[127:64] != 0 || p[63:0] > SIGN_BIT) begin ovf = 1; m = SIGN_BIT; end
			else m = p[63:0];
			if (e[i]) begin
				p = mul_round(m, bm);
				if (p[127:64] != 0 || p[63:0] > SIGN_BIT) begin ovf = 1; m = SIGN_BIT; end
				else m = p[63:0];
			end
		end
		if (ovf) begin
			flag(ST_SAT);
			return neg ? SIGN_BIT : POS_MAX;
		end
		return fit(neg, {64'd0, m});
	endfunction

	function automatic void reduce_one();
		logic [63:0] a, b, r;
		if (n_ops == 0 || n_vals < 2) return;
		a = vstk[n_vals - 2];
		b = vstk[n_vals - 1];
		case (ostk[n_ops - 1])
			OP_ADD: r = fx_add(a, b, 0);
			OP_SUB: r = fx_add(a, b, 1);
			OP_MUL: r = fit(a[63] ^ b[63], mul_round(mag(a), mag(b)));
			default: r = fx_div(a, b);
		endcase
		vstk[n_vals - 2] = r;
		n_vals--;
		n_ops--;
	endfunction

	function automatic void reduce_stack();
		while (n_ops > 0 && n_vals >= 2 && !stopped()) reduce_one();
	endfunction

	function automatic void close_literal();
		if (pow_wait) begin
			if (n_vals > 0) vstk[n_vals - 1] = fx_pow(vstk[n_vals - 1], lit_acc);
			pow_wait = 0;
		end else if (n_vals < 3) begin
			vstk[n_vals] = lit_acc << FRAC;
			n_vals++;
		end
		lit_acc = 0;
		in_lit = 0;
	endfunction

	function automatic void push_operator(op_t code);
		if (code == OP_ADD || code == OP_SUB) reduce_stack();
		else if (n_ops > 0 && ostk[n_ops - 1] >= OP_MUL) reduce_one();
		if (!stopped() && n_ops < 2) begin
			ostk[n_ops] = code;
			n_ops++;
		end
	endfunction

	// advance the evaluator by one character; queue a result on the last one
	task automatic evaluate_char(item_t it);
		result_t r;
		logic [7:0] c;
		c = it.character;
		if (!stopped()) begin
			if (c >= "0" && c <= "9") begin
				if (star_wait) begin
					star_wait = 0;
					push_operator(OP_MUL);
				end
				if (!stopped()) begin
					lit_acc = lit_acc * 10 + (c - "0");
					if (lit_acc > LIT_MAX) begin
						lit_acc = LIT_MAX;
						flag(ST_SAT);
					end
					in_lit = 1;
				end
			end else if (c == "*") begin
				if (star_wait) begin
					star_wait = 0;
					pow_wait = 1;
				end else if (!in_lit) flag(ST_BAD);
				else begin
					close_literal();
					star_wait = 1;
				end
			end else if (c == "+" || c == "-" || c == "/") begin
				if (star_wait || !in_lit) flag(ST_BAD);
				else begin
					close_literal();
					push_operator(c == "+" ? OP_ADD : (c == "-" ? OP_SUB : OP_DIV));
				end
			end else flag(ST_BAD);
		end
		if (it.last) begin
			if (!stopped()) begin
				if (star_wait || !in_lit) flag(ST_BAD);
				else begin
					close_literal();
					reduce_stack();
				end
			end
			r.value = (stopped() || n_vals == 0) ? 64'd0 : vstk[0];
			r.status = err;
			expected_results.push_back(r);
			clear_eval();
		end
	endtask

	// one beat into the input queue after a random gap; push stays high
	// into the next beat when there is no gap
	task automatic send_char(logic [7:0] c, bit is_last);
		item_t it;
		int gap;
		gap = push_hold ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.character = c;
		it.last = is_last;
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		evaluate_char(it);
	endtask

	task automatic send_string(string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
	endtask

	function automatic string rand_literal();
		string s;
		int len;
		case ($urandom_range(0, 9))
			0: len = $urandom_range(8, 12);
			1, 2, 3: len = 2;
			default: len = 1;
		endcase
		s = "";
		for (int i = 0; i < len; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
		return s;
	endfunction

	function automatic string rand_expression();
		string s, ops;
		int terms;
		ops = "+-*/";
		terms = $urandom_range(1, 5);
		s = rand_literal();
		for (int i = 1; i < terms; i++) begin
			if ($urandom_range(0, 5) == 0)
				s = {s, "**", string'(8'("0" + $urandom_range(0, 9)))};
			else
				s = {s, string'(ops[$urandom_range(0, 3)]), rand_literal()};
		end
		return s;
	endfunction

	task automatic test_directed();
		send_string("0");
		send_string("2147483647");
		send_string("99999999999");
		send_string("7+5");
		send_string("3-10");
		send_string("6*7");
		send_string("22/7");
		send_string("1/0");
		send_string("2**10");
		send_string("0**0");
		send_string("0-3**3");
		send_string("2**3**2");
		send_string("65536*65536*2");
		send_string("0-2147483647*2147483647-2147483647");
		send_string("+5");
		send_string("5+");
		send_string("5***2");
		send_string("5*+2");
		send_string("5a3");
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b1);
		send_string("1-2*3/4+5");
	endtask

	task automatic test_random();
		string s;
		for (int n = 0; n < 1500;) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: one to four random bytes, the final one marked last
				for (int i = $urandom_range(1, 4); i > 0; i--) begin
					send_char(8'($urandom_range(0, 255)), i == 1);
					n++;
				end
			end else begin
				s = rand_expression();
				push_hold = ($urandom_range(0, 3) == 0);
				send_string(s);
				push_hold = 0;
				n += s.len();
			end
		end
	endtask

	// pop side: random stall per beat, compare oldest expectation
	initial begin
		result_t exp_r;
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result value=%h status=%0d",
						result.value, result.status);
			end else begin
				exp_r = expected_results.pop_front();
				if (result.value !== exp_r.value || result.status !== exp_r.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
							exp_r.value, exp_r.status, result.value, result.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG && !timed_out) begin
			timed_out = 1;
			$display("infix_expression_evaluator_unit verification failed");
			$finish;
		end
	end

	initial begin
		clear_eval();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		push <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("infix_expression_evaluator_unit verification clean");
		else
			$display("infix_expression_evaluator_unit verification failed");
		$finish;
	end

endmodule
